// ----- rtl/core/cwm_pkg.sv -----
// Package of the card word machine core: widths, status codes, character
// constants, microcode types and the read-only control store.
// No dependencies.
`timescale 1ns / 1ps

package cwm_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ADDR_W   = 7;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned STEP_W   = 4;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [STEP_W-1:0]   step_t;

  localparam action_t ACT_LOAD  = 2'd0;
  localparam action_t ACT_EXEC  = 2'd1;
  localparam action_t ACT_DATA  = 2'd2;
  localparam action_t ACT_START = 2'd3;

  localparam status_t ST_OK   = 3'd0;
  localparam status_t ST_REQ  = 3'd1;
  localparam status_t ST_PUT  = 3'd2;
  localparam status_t ST_HALT = 3'd3;
  localparam status_t ST_ERR  = 3'd4;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;

  typedef enum logic [3:0] {
    OP_ACCEPT = 4'd0,
    OP_LOAD   = 4'd1,
    OP_EXEC   = 4'd2,
    OP_DATA   = 4'd3,
    OP_START  = 4'd4,
    OP_DECODE = 4'd5,
    OP_OPSEL  = 4'd6,
    OP_PUT    = 4'd7,
    OP_OPER   = 4'd8
  } dp_op_t;

  typedef enum logic {
    BR_SEQ    = 1'b0,
    BR_ACTION = 1'b1
  } br_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_LOAD   = 4'd1;
  localparam step_t STEP_EXEC   = 4'd2;
  localparam step_t STEP_DATA   = 4'd3;
  localparam step_t STEP_START  = 4'd4;
  localparam step_t STEP_DECODE = 4'd5;
  localparam step_t STEP_OPSEL  = 4'd6;
  localparam step_t STEP_PUT    = 4'd7;
  localparam step_t STEP_OPER   = 4'd8;

  typedef struct packed {
    logic   ready;
    logic   wait_out;
    dp_op_t op;
    br_t    br;
    step_t  target;
  } ucode_t;

  typedef struct packed {
    dp_op_t op;
    logic   fire;
  } seq_ctl_t;

  typedef struct packed {
    logic out_free;
    logic take;
    logic done;
  } dp_flags_t;

  // Control store. A step ends at idle when it emits a final result, jumps to
  // its target when the datapath asks for it, and otherwise falls through.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    begin
      w = '{ready: 1'b1, wait_out: 1'b0, op: OP_ACCEPT, br: BR_ACTION, target: STEP_IDLE};
      unique case (s)
        STEP_IDLE:   w = '{1'b1, 1'b0, OP_ACCEPT, BR_ACTION, STEP_IDLE};
        STEP_LOAD:   w = '{1'b0, 1'b1, OP_LOAD,   BR_SEQ,    STEP_IDLE};
        STEP_EXEC:   w = '{1'b0, 1'b1, OP_EXEC,   BR_SEQ,    STEP_DECODE};
        STEP_DATA:   w = '{1'b0, 1'b1, OP_DATA,   BR_SEQ,    STEP_IDLE};
        STEP_START:  w = '{1'b0, 1'b1, OP_START,  BR_SEQ,    STEP_IDLE};
        STEP_DECODE: w = '{1'b0, 1'b0, OP_DECODE, BR_SEQ,    STEP_IDLE};
        STEP_OPSEL:  w = '{1'b0, 1'b1, OP_OPSEL,  BR_SEQ,    STEP_OPER};
        STEP_PUT:    w = '{1'b0, 1'b1, OP_PUT,    BR_SEQ,    STEP_PUT};
        STEP_OPER:   w = '{1'b0, 1'b1, OP_OPER,   BR_SEQ,    STEP_IDLE};
        default:     w = '{1'b1, 1'b0, OP_ACCEPT, BR_ACTION, STEP_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

// ----- rtl/core/cwm_if.sv -----
// Channel interfaces of the card word machine core: the command channel and
// the result channel, each with valid, ready and payload.
// Depends on cwm_pkg.
`timescale 1ns / 1ps

interface cwm_in_if;
  import cwm_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   address;
  logic [WORD_W-1:0]   word;

  modport source (output valid, output action, output address, output word, input ready);
  modport sink (input valid, input action, input address, input word, output ready);
endinterface

interface cwm_out_if;
  import cwm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   word_out;
  logic [ADDR_W-1:0]   block_address;
  logic                compare_flag;
  logic                last;

  modport source (output valid, output status, output word_out, output block_address,
                  output compare_flag, output last, input ready);
  modport sink (input valid, input status, input word_out, input block_address,
                input compare_flag, input last, output ready);
endinterface

// ----- rtl/core/cwm_seq.sv -----
// Microcode sequencer of the card word machine core: step counter, control
// store lookup and next-step selection.
// Depends on cwm_pkg.
`timescale 1ns / 1ps

module cwm_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  cwm_pkg::action_t    cmd_action,
  input  cwm_pkg::dp_flags_t  flags,
  output logic                cmd_ready,
  output cwm_pkg::seq_ctl_t   ctl
);
  import cwm_pkg::*;

  step_t  step;
  step_t  step_next;
  ucode_t cw;
  logic   fire;

  assign cw        = ucode_rom(step);
  assign cmd_ready = cw.ready;
  assign fire      = (!cw.ready || cmd_valid) && (!cw.wait_out || flags.out_free);
  assign ctl       = '{op: cw.op, fire: fire};

  always_comb begin
    step_next = step;
    if (fire) begin
      unique case (cw.br)
        BR_ACTION: begin
          unique case (cmd_action)
            ACT_LOAD:  step_next = STEP_LOAD;
            ACT_EXEC:  step_next = STEP_EXEC;
            ACT_DATA:  step_next = STEP_DATA;
            ACT_START: step_next = STEP_START;
            default:   step_next = STEP_IDLE;
          endcase
        end
        BR_SEQ: begin
          priority if (flags.done) begin
            step_next = STEP_IDLE;
          end else if (flags.take) begin
            step_next = cw.target;
          end else begin
            step_next = step + step_t'(1);
          end
        end
        default: step_next = STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- rtl/core/cwm_dp.sv -----
// Datapath of the card word machine core: main store, machine registers,
// instruction decode and the result register.
// Depends on cwm_pkg.
`timescale 1ns / 1ps

module cwm_dp #(
  parameter int unsigned STORE_WORDS = 100,
  parameter int unsigned BLOCK_WORDS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cwm_pkg::seq_ctl_t             ctl,
  input  logic [cwm_pkg::ADDR_W-1:0]    cmd_address,
  input  logic [cwm_pkg::WORD_W-1:0]    cmd_word,
  input  logic                          rsp_ready,
  output cwm_pkg::dp_flags_t            flags,
  output logic                          rsp_valid,
  output cwm_pkg::status_t              rsp_status,
  output logic [cwm_pkg::WORD_W-1:0]    rsp_word_out,
  output logic [cwm_pkg::ADDR_W-1:0]    rsp_block_address,
  output logic                          rsp_compare_flag,
  output logic                          rsp_last
);
  import cwm_pkg::*;

  localparam int unsigned AW = $clog2(STORE_WORDS);
  localparam logic [ADDR_W-1:0] STORE_LIM = ADDR_W'(STORE_WORDS);
  localparam logic [CNT_W-1:0]  BLK_CNT   = CNT_W'(BLOCK_WORDS);
  localparam logic [CNT_W-1:0]  BLK_LAST  = CNT_W'(BLOCK_WORDS - 1);

  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [WORD_W-1:0] rdata;

  logic [ADDR_W-1:0] address_l, address_l_next;
  logic [WORD_W-1:0] word_l, word_l_next;
  logic [WORD_W-1:0] ir, ir_next;
  logic [ADDR_W-1:0] ic, ic_next;
  logic [WORD_W-1:0] r, r_next;
  logic              c, c_next;
  logic [ADDR_W-1:0] fill_ptr, fill_ptr_next;
  logic [CNT_W-1:0]  fill_rem, fill_rem_next;
  logic [CNT_W-1:0]  pd_cnt, pd_cnt_next;
  logic [ADDR_W-1:0] pd_ptr, pd_ptr_next;
  logic [ADDR_W-1:0] pd_base, pd_base_next;

  logic              out_free;
  logic              emit;
  status_t           e_status;
  logic [WORD_W-1:0] e_word;
  logic [ADDR_W-1:0] e_blk;
  logic              e_last;
  logic              take;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [WORD_W-1:0] wd;
  logic              re;
  logic [ADDR_W-1:0] ra;

  logic [7:0]        c0, c1, c2, c3;
  logic              is_halt, digits_ok, is_gd, is_pd, is_lr, is_sr, is_cr, is_bt;
  logic [ADDR_W-1:0] dec_base, dec_addr;
  logic              blk_bad, addr_bad;

  assign c0 = ir[31:24];
  assign c1 = ir[23:16];
  assign c2 = ir[15:8];
  assign c3 = ir[7:0];

  assign is_halt   = (c0 == CH_H);
  assign digits_ok = (c2 >= CH_0) && (c2 <= CH_9) && (c3 >= CH_0) && (c3 <= CH_9);
  assign is_gd     = (c0 == CH_G) && (c1 == CH_D);
  assign is_pd     = (c0 == CH_P) && (c1 == CH_D);
  assign is_lr     = (c0 == CH_L) && (c1 == CH_R);
  assign is_sr     = (c0 == CH_S) && (c1 == CH_R);
  assign is_cr     = (c0 == CH_C) && (c1 == CH_R);
  assign is_bt     = (c0 == CH_B) && (c1 == CH_T);
  assign dec_base  = {3'b000, c2[3:0]} * 7'd10;
  assign dec_addr  = dec_base + {3'b000, c3[3:0]};
  assign blk_bad   = ({1'b0, dec_base} + 8'(BLOCK_WORDS)) > 8'(STORE_WORDS);
  assign addr_bad  = dec_addr >= STORE_LIM;

  assign out_free = !rsp_valid || rsp_ready;
  assign flags    = '{out_free: out_free, take: take, done: emit && e_last};

  always_comb begin
    emit           = 1'b0;
    e_status       = ST_OK;
    e_blk          = '0;
    e_last         = 1'b1;
    take           = 1'b0;
    we             = 1'b0;
    wa             = address_l;
    wd             = word_l;
    re             = 1'b0;
    ra             = ic;
    address_l_next = address_l;
    word_l_next    = word_l;
    ir_next        = ir;
    ic_next        = ic;
    r_next         = r;
    c_next         = c;
    fill_ptr_next  = fill_ptr;
    fill_rem_next  = fill_rem;
    pd_cnt_next    = pd_cnt;
    pd_ptr_next    = pd_ptr;
    pd_base_next   = pd_base;
    unique case (ctl.op)
      OP_ACCEPT: begin
        address_l_next = cmd_address;
        word_l_next    = cmd_word;
      end
      OP_LOAD: begin
        emit = 1'b1;
        if (address_l < STORE_LIM) begin
          we = 1'b1;
        end else begin
          e_status = ST_ERR;
        end
      end
      OP_START: begin
        emit          = 1'b1;
        ic_next       = '0;
        r_next        = '0;
        c_next        = 1'b0;
        fill_ptr_next = '0;
        fill_rem_next = '0;
      end
      OP_DATA: begin
        emit = 1'b1;
        if (fill_rem == '0 || fill_ptr >= STORE_LIM) begin
          fill_rem_next = '0;
        end else begin
          we            = 1'b1;
          wa            = fill_ptr;
          fill_ptr_next = fill_ptr + 7'd1;
          fill_rem_next = fill_rem - 4'd1;
          if (fill_rem != 4'd1) begin
            e_status = ST_REQ;
            e_blk    = fill_ptr + 7'd1;
          end
        end
      end
      OP_EXEC: begin
        priority if (fill_rem != '0) begin
          emit     = 1'b1;
          e_status = ST_REQ;
          e_blk    = fill_ptr;
        end else if (ic >= STORE_LIM) begin
          emit     = 1'b1;
          e_status = ST_ERR;
        end else begin
          re      = 1'b1;
          ra      = ic;
          ic_next = ic + 7'd1;
          take    = 1'b1;
        end
      end
      OP_DECODE: begin
        ir_next = rdata;
      end
      OP_OPSEL: begin
        emit = 1'b1;
        priority if (is_halt) begin
          e_status = ST_HALT;
        end else if (!digits_ok) begin
          e_status = ST_ERR;
        end else if (is_gd || is_pd) begin
          priority if (blk_bad) begin
            e_status = ST_ERR;
          end else if (is_gd) begin
            fill_ptr_next = dec_base;
            fill_rem_next = BLK_CNT;
            e_status      = ST_REQ;
            e_blk         = dec_base;
          end else begin
            emit         = 1'b0;
            re           = 1'b1;
            ra           = dec_base;
            pd_ptr_next  = dec_base;
            pd_base_next = dec_base;
            pd_cnt_next  = '0;
          end
        end else if (addr_bad) begin
          e_status = ST_ERR;
        end else if (is_lr || is_cr) begin
          emit = 1'b0;
          re   = 1'b1;
          ra   = dec_addr;
          take = 1'b1;
        end else if (is_sr) begin
          we = 1'b1;
          wa = dec_addr;
          wd = r;
        end else if (is_bt) begin
          if (c) begin
            ic_next = dec_addr;
          end
        end
      end
      OP_PUT: begin
        emit     = 1'b1;
        e_status = ST_PUT;
        e_blk    = pd_base;
        e_last   = (pd_cnt == BLK_LAST);
        if (pd_cnt != BLK_LAST) begin
          re          = 1'b1;
          ra          = pd_ptr + 7'd1;
          pd_ptr_next = pd_ptr + 7'd1;
          pd_cnt_next = pd_cnt + 4'd1;
          take        = 1'b1;
        end
      end
      OP_OPER: begin
        emit = 1'b1;
        if (is_lr) begin
          r_next = rdata;
        end else begin
          c_next = (r == rdata);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    e_word = (ctl.op == OP_PUT) ? rdata : r_next;
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && we) begin
      mem[wa[AW-1:0]] <= wd;
    end
    if (ctl.fire && re) begin
      rdata <= mem[ra[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir       <= '0;
      ic       <= '0;
      r        <= '0;
      c        <= 1'b0;
      fill_ptr <= '0;
      fill_rem <= '0;
    end else if (ctl.fire) begin
      ir       <= ir_next;
      ic       <= ic_next;
      r        <= r_next;
      c        <= c_next;
      fill_ptr <= fill_ptr_next;
      fill_rem <= fill_rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      address_l <= address_l_next;
      word_l    <= word_l_next;
      pd_cnt    <= pd_cnt_next;
      pd_ptr    <= pd_ptr_next;
      pd_base   <= pd_base_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.fire && emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && emit) begin
      rsp_status        <= e_status;
      rsp_word_out      <= e_word;
      rsp_block_address <= e_blk;
      rsp_compare_flag  <= c_next;
      rsp_last          <= e_last;
    end
  end

endmodule

// ----- rtl/core/card_word_machine_core_unit.sv -----
// Top level of the card word machine core: joins the microcode sequencer
// and the datapath to the command and result channels.
// Depends on cwm_pkg, cwm_if, cwm_seq and cwm_dp.
`timescale 1ns / 1ps

// The core runs one command transaction at a time under a small microcode
// program and takes the next command only after the previous one has placed
// its last result in the output register. Loading a word, starting a job and
// delivering a GD data word take the accept step and a work step that emits. An
// instruction runs the accept, fetch, decode and operand-select steps, and an
// operate step for LR and CR; fetch emits at once when a GD fill is pending or
// the counter is past the store. A PD then runs one put step per block word,
// emitting one result per cycle while the consumer keeps ready high. The steps
// follow from the single read port of the store: the fetch read, the decode
// step and the operand read each need a step of their own. A stalled result
// channel holds the program at the next step that can emit.

module card_word_machine_core_unit #(
  parameter int unsigned STORE_WORDS = 100,
  parameter int unsigned BLOCK_WORDS = 10
) (
  input  logic      clk,
  input  logic      rst,
  cwm_in_if.sink    cmd,
  cwm_out_if.source rsp
);
  import cwm_pkg::*;

  seq_ctl_t  ctl;
  dp_flags_t flags;

  cwm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd.valid),
    .cmd_action (cmd.action),
    .flags      (flags),
    .cmd_ready  (cmd.ready),
    .ctl        (ctl)
  );

  cwm_dp #(
    .STORE_WORDS (STORE_WORDS),
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .cmd_address       (cmd.address),
    .cmd_word          (cmd.word),
    .rsp_ready         (rsp.ready),
    .flags             (flags),
    .rsp_valid         (rsp.valid),
    .rsp_status        (rsp.status),
    .rsp_word_out      (rsp.word_out),
    .rsp_block_address (rsp.block_address),
    .rsp_compare_flag  (rsp.compare_flag),
    .rsp_last          (rsp.last)
  );

endmodule

// ----- sim/card_word_machine_core_unit_test.sv -----
// Self-checking testbench of card_word_machine_core_unit: a directed program
// followed by random program fragments, checked against a behavioral machine.
// Depends on cwm_pkg, cwm_if and the RTL of the core.
`timescale 1ns / 1ps

module card_word_machine_core_unit_test;
  import cwm_pkg::*;

  localparam int STORE_WORDS = 100;
  localparam int BLOCK_WORDS = 10;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 32;

  typedef struct packed {
    action_t           action;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] word;
  } command_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] word_out;
    logic [ADDR_W-1:0] block_address;
    logic              compare_flag;
    logic              last;
  } response_t;

  typedef struct packed {
    command_t  cmd;
    logic      typed;
    response_t want;
  } script_row_t;

  logic clk;
  logic rst;

  cwm_in_if  cmd();
  cwm_out_if rsp();

  card_word_machine_core_unit #(
    .STORE_WORDS(STORE_WORDS),
    .BLOCK_WORDS(BLOCK_WORDS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  logic [WORD_W-1:0] mem_image [STORE_WORDS];
  bit                mem_known [STORE_WORDS];
  logic [ADDR_W-1:0] ic_q;
  logic [WORD_W-1:0] reg_r;
  logic              toggle_c;
  logic [ADDR_W-1:0] fill_at;
  logic [CNT_W-1:0]  fill_left;

  response_t   awaited_responses[$];
  script_row_t directed_plan[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          send_idle_by_phase[4] = '{0, 84, 0, 25};
  int          recv_stall_by_phase[4] = '{0, 0, 84, 25};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_digit(logic [7:0] ch);
    return ch >= CH_0 && ch <= CH_9;
  endfunction

  function automatic bit op_is(logic [WORD_W-1:0] ir, logic [7:0] a, logic [7:0] b);
    return ir[31:24] == a && ir[23:16] == b;
  endfunction

  function automatic void append_response(response_t r);
    awaited_responses.insert(awaited_responses.size(), r);
  endfunction

  function automatic void add_plan_row(script_row_t row);
    directed_plan.insert(directed_plan.size(), row);
  endfunction

  function automatic void queue_response(status_t s, logic [WORD_W-1:0] w,
                                         logic [ADDR_W-1:0] blk, logic lst);
    response_t r;
    r.status        = s;
    r.word_out      = w;
    r.block_address = blk;
    r.compare_flag  = toggle_c;
    r.last          = lst;
    append_response(r);
  endfunction

  function automatic void run_instruction();
    logic [WORD_W-1:0] ir;
    int                base;
    int                addr;
    if (fill_left != 0) begin
      queue_response(ST_REQ, reg_r, fill_at, 1'b1);
      return;
    end
    if (ic_q >= STORE_WORDS) begin
      queue_response(ST_ERR, reg_r, '0, 1'b1);
      return;
    end
    ir = mem_image[ic_q];
    ic_q = ic_q + 1'b1;
    if (ir[31:24] == CH_H) begin
      queue_response(ST_HALT, reg_r, '0, 1'b1);
      return;
    end
    if (!is_digit(ir[15:8]) || !is_digit(ir[7:0])) begin
      queue_response(ST_ERR, reg_r, '0, 1'b1);
      return;
    end
    base = int'(ir[15:8] - CH_0) * 10;
    addr = base + int'(ir[7:0] - CH_0);
    if (op_is(ir, CH_G, CH_D) || op_is(ir, CH_P, CH_D)) begin
      if (base + BLOCK_WORDS > STORE_WORDS) begin
        queue_response(ST_ERR, reg_r, '0, 1'b1);
      end else if (op_is(ir, CH_G, CH_D)) begin
        fill_at = ADDR_W'(base);
        fill_left = CNT_W'(BLOCK_WORDS);
        queue_response(ST_REQ, reg_r, ADDR_W'(base), 1'b1);
      end else begin
        for (int x = 0; x < BLOCK_WORDS; x++)
          queue_response(ST_PUT, mem_image[base + x], ADDR_W'(base), x == BLOCK_WORDS - 1);
      end
      return;
    end
    if (addr >= STORE_WORDS) begin
      queue_response(ST_ERR, reg_r, '0, 1'b1);
      return;
    end
    if (op_is(ir, CH_L, CH_R)) begin
      reg_r = mem_image[addr];
    end else if (op_is(ir, CH_S, CH_R)) begin
      mem_image[addr] = reg_r;
      mem_known[addr] = 1'b1;
    end else if (op_is(ir, CH_C, CH_R)) begin
      toggle_c = reg_r == mem_image[addr];
    end else if (op_is(ir, CH_B, CH_T)) begin
      if (toggle_c) ic_q = ADDR_W'(addr);
    end
    queue_response(ST_OK, reg_r, '0, 1'b1);
  endfunction

  function automatic void machine_step(command_t c);
    case (c.action)
      ACT_LOAD: begin
        if (c.address >= STORE_WORDS) begin
          queue_response(ST_ERR, reg_r, '0, 1'b1);
        end else begin
          mem_image[c.address] = c.word;
          mem_known[c.address] = 1'b1;
          queue_response(ST_OK, reg_r, '0, 1'b1);
        end
      end
      ACT_EXEC: begin
        run_instruction();
      end
      ACT_DATA: begin
        if (fill_left == 0 || fill_at >= STORE_WORDS) begin
          fill_left = '0;
          queue_response(ST_OK, reg_r, '0, 1'b1);
        end else begin
          mem_image[fill_at] = c.word;
          mem_known[fill_at] = 1'b1;
          fill_at = fill_at + 1'b1;
          fill_left = fill_left - 1'b1;
          if (fill_left != 0) queue_response(ST_REQ, reg_r, fill_at, 1'b1);
          else queue_response(ST_OK, reg_r, '0, 1'b1);
        end
      end
      default: begin
        ic_q = '0;
        reg_r = '0;
        toggle_c = 1'b0;
        fill_at = '0;
        fill_left = '0;
        queue_response(ST_OK, reg_r, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] random_instruction();
    logic [7:0] op_a;
    logic [7:0] op_b;
    logic [7:0] tens;
    logic [7:0] ones;
    op_a = 8'($urandom);
    op_b = 8'($urandom);
    case ($urandom_range(0, 15))
      0, 1, 2: begin op_a = CH_L; op_b = CH_R; end
      3, 4: begin op_a = CH_S; op_b = CH_R; end
      5, 6, 7: begin op_a = CH_C; op_b = CH_R; end
      8, 9: begin op_a = CH_B; op_b = CH_T; end
      10: begin op_a = CH_G; op_b = CH_D; end
      11: begin op_a = CH_P; op_b = CH_D; end
      12: op_a = CH_H;
      default: ;
    endcase
    tens = CH_0 + 8'($urandom_range(0, 9));
    ones = CH_0 + 8'($urandom_range(0, 9));
    case ($urandom_range(0, 23))
      0: tens = 8'($urandom);
      1: ones = 8'($urandom);
      default: ;
    endcase
    return {op_a, op_b, tens, ones};
  endfunction

  // Stimulus is drawn against the current machine state, so that no store word
  // is ever read before it has been written: a missing word is loaded first.
  function automatic command_t next_command();
    command_t          c;
    int                r;
    int                gap;
    int                base;
    int                addr;
    logic [WORD_W-1:0] ir;
    c.address = 7'($urandom_range(0, 127));
    c.word = ($urandom_range(0, 1) != 0) ? random_instruction() : $urandom;
    r = $urandom_range(0, 99);
    if (fill_left != 0) begin
      if (r < 80) begin
        c.action = ACT_DATA;
      end else if (r < 90) begin
        c.action = ACT_EXEC;
      end else if (r < 95) begin
        c.action = ACT_START;
      end else begin
        c.action = ACT_LOAD;
      end
      return c;
    end
    if (r < 12) begin
      c.action = ACT_LOAD;
      case ($urandom_range(0, 9))
        0, 1: c.address = 7'($urandom_range(STORE_WORDS, 127));
        2, 3, 4, 5: c.address = 7'($urandom_range(0, 19));
        default: c.address = 7'($urandom_range(0, STORE_WORDS - 1));
      endcase
      return c;
    end
    if (r < 20) begin
      c.action = ACT_START;
      return c;
    end
    if (r < 26) begin
      c.action = ACT_DATA;
      return c;
    end
    c.action = ACT_EXEC;
    gap = -1;
    if (ic_q < STORE_WORDS) begin
      if (!mem_known[ic_q]) begin
        gap = ic_q;
        c.word = random_instruction();
      end else begin
        ir = mem_image[ic_q];
        if (ir[31:24] != CH_H && is_digit(ir[15:8]) && is_digit(ir[7:0])) begin
          base = int'(ir[15:8] - CH_0) * 10;
          addr = base + int'(ir[7:0] - CH_0);
          if (op_is(ir, CH_P, CH_D) && base + BLOCK_WORDS <= STORE_WORDS) begin
            for (int x = BLOCK_WORDS - 1; x >= 0; x--)
              if (!mem_known[base + x]) gap = base + x;
          end else if ((op_is(ir, CH_L, CH_R) || op_is(ir, CH_C, CH_R)) &&
                       addr < STORE_WORDS && !mem_known[addr]) begin
            gap = addr;
          end
          if ($urandom_range(0, 1) != 0) c.word = reg_r;
        end
      end
    end
    if (gap >= 0) begin
      c.action = ACT_LOAD;
      c.address = 7'(gap);
    end
    return c;
  endfunction

  function automatic script_row_t step_row(action_t a, logic [ADDR_W-1:0] ad,
                                           logic [WORD_W-1:0] w);
    script_row_t row;
    row = '0;
    row.cmd = '{a, ad, w};
    return row;
  endfunction

  function automatic script_row_t checked_row(action_t a, logic [ADDR_W-1:0] ad,
                                              logic [WORD_W-1:0] w, status_t s,
                                              logic [WORD_W-1:0] wo,
                                              logic [ADDR_W-1:0] blk, logic cf);
    script_row_t row;
    row.cmd = '{a, ad, w};
    row.typed = 1'b1;
    row.want = '{s, wo, blk, cf, 1'b1};
    return row;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    if (mismatch_count < 50)
      $display("mismatch in %s: got %h, expected %h at %0t ns", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic send_command(command_t c, logic typed, response_t want);
    int n0;
    while ($urandom_range(0, 99) < send_idle) begin
      cmd.valid = 1'b0;
      @(negedge clk);
    end
    cmd.valid = 1'b1;
    cmd.action = c.action;
    cmd.address = c.address;
    cmd.word = c.word;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    n0 = awaited_responses.size();
    machine_step(c);
    if (typed) begin
      while (awaited_responses.size() > n0) void'(awaited_responses.pop_back());
      append_response(want);
    end
    @(negedge clk);
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready = !rst && ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    response_t exp_r;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (awaited_responses.size() == 0) begin
        report_mismatch("unexpected result status", WORD_W'(rsp.status), '0);
      end else begin
        exp_r = awaited_responses.pop_front();
        if (rsp.status !== exp_r.status)
          report_mismatch("status", WORD_W'(rsp.status), WORD_W'(exp_r.status));
        if (rsp.word_out !== exp_r.word_out)
          report_mismatch("word_out", rsp.word_out, exp_r.word_out);
        if (rsp.block_address !== exp_r.block_address)
          report_mismatch("block_address", WORD_W'(rsp.block_address),
                          WORD_W'(exp_r.block_address));
        if (rsp.compare_flag !== exp_r.compare_flag)
          report_mismatch("compare_flag", WORD_W'(rsp.compare_flag),
                          WORD_W'(exp_r.compare_flag));
        if (rsp.last !== exp_r.last)
          report_mismatch("last", WORD_W'(rsp.last), WORD_W'(exp_r.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("card_word_machine_core_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    command_t c;
    int       counted;
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.action = ACT_LOAD;
    cmd.address = '0;
    cmd.word = '0;
    ic_q = '0;
    reg_r = '0;
    toggle_c = 1'b0;
    fill_at = '0;
    fill_left = '0;
    foreach (mem_image[i]) begin
      mem_image[i] = '0;
      mem_known[i] = 1'b0;
    end

    // The program fills the top block with GD, dumps it with PD, sets the
    // toggle by comparing R with its own source, and branches into the block,
    // whose last words hit a non-digit address, an unknown opcode and a halt, after
    // which the counter has run past the end of the store.
    add_plan_row(checked_row(ACT_DATA, 7'd0, 32'h0, ST_OK, 32'h0, 7'd0, 1'b0));
    add_plan_row(checked_row(ACT_LOAD, 7'd127, 32'hFFFF_FFFF, ST_ERR, 32'h0,
                             7'd0, 1'b0));
    add_plan_row(step_row(ACT_LOAD, 7'd0, "GD90"));
    add_plan_row(step_row(ACT_LOAD, 7'd1, "PD90"));
    add_plan_row(step_row(ACT_LOAD, 7'd2, "LR99"));
    add_plan_row(step_row(ACT_LOAD, 7'd3, "CR99"));
    add_plan_row(step_row(ACT_LOAD, 7'd4, "BT97"));
    add_plan_row(step_row(ACT_EXEC, 7'd0, 32'h0));
    add_plan_row(checked_row(ACT_EXEC, 7'd127, 32'hFFFF_FFFF, ST_REQ, 32'h0,
                             7'd90, 1'b0));
    add_plan_row(step_row(ACT_DATA, 7'd127, 32'h0000_0000));
    add_plan_row(step_row(ACT_DATA, 7'd0, 32'hFFFF_FFFF));
    add_plan_row(step_row(ACT_DATA, 7'd64, 32'h8000_0001));
    add_plan_row(step_row(ACT_DATA, 7'd63, 32'h7FFF_FFFE));
    add_plan_row(step_row(ACT_DATA, 7'd0, 32'hA5A5_5A5A));
    add_plan_row(step_row(ACT_DATA, 7'd0, 32'h5A5A_A5A5));
    add_plan_row(step_row(ACT_DATA, 7'd0, 32'h1234_5678));
    add_plan_row(step_row(ACT_DATA, 7'd0, "LR9Z"));
    add_plan_row(step_row(ACT_DATA, 7'd0, "ZZ12"));
    add_plan_row(step_row(ACT_DATA, 7'd0, "HALT"));
    add_plan_row(step_row(ACT_EXEC, 7'd0, 32'h0));
    add_plan_row(step_row(ACT_EXEC, 7'd0, 32'h0));
    add_plan_row(step_row(ACT_EXEC, 7'd0, 32'h0));
    add_plan_row(step_row(ACT_EXEC, 7'd0, 32'h0));
    add_plan_row(checked_row(ACT_EXEC, 7'd0, 32'h0, ST_ERR, "HALT", 7'd0, 1'b1));
    add_plan_row(step_row(ACT_EXEC, 7'd0, 32'h0));
    add_plan_row(checked_row(ACT_EXEC, 7'd0, 32'h0, ST_HALT, "HALT", 7'd0, 1'b1));
    add_plan_row(checked_row(ACT_EXEC, 7'd0, 32'h0, ST_ERR, "HALT", 7'd0, 1'b1));
    add_plan_row(checked_row(ACT_START, 7'd127, 32'hFFFF_FFFF, ST_OK, 32'h0,
                             7'd0, 1'b0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_plan[i])
      send_command(directed_plan[i].cmd, directed_plan[i].typed, directed_plan[i].want);

    for (int p = 0; p < 4; p++) begin
      send_idle = send_idle_by_phase[p];
      recv_stall = recv_stall_by_phase[p];
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        c = next_command();
        if (!(c.action == ACT_DATA && fill_left == 0)) counted++;
        send_command(c, 1'b0, '0);
      end
    end
    cmd.valid = 1'b0;

    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("card_word_machine_core_unit regression: pass");
    end else begin
      $display("card_word_machine_core_unit regression: fail");
    end
    $finish;
  end

endmodule
